@@ design/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assertion macros
// concurrent checks that compile away when SYNTHESIS is defined
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// antecedent implies consequent in the following cycle
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_SAME(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ design/cpds_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cpds_pkg
// types, fixed-point constants and microcode for the cart-pole step core
// ---------------------------------------------------------------------------
`default_nettype none

package cpds_pkg;

  localparam int WORD_W = 32;
  localparam int FRAC_W = 24;
  localparam int CFG_W  = 31;

  typedef struct packed {
    logic               kind;
    logic               push_right;
    logic signed [31:0] load_position;
    logic signed [31:0] load_velocity;
    logic signed [31:0] load_angle;
    logic signed [31:0] load_angular_rate;
  } in_t;

  typedef struct packed {
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic signed [31:0] angle;
    logic signed [31:0] angular_rate;
    logic               terminated;
  } out_t;

  // config register indexes
  typedef enum logic [1:0] {
    REG_FORCE   = 2'd0,
    REG_TAU     = 2'd1,
    REG_POS_LIM = 2'd2,
    REG_ANG_LIM = 2'd3
  } reg_idx_t;

  localparam logic [30:0] RST_FORCE   = 31'd167772160;
  localparam logic [30:0] RST_TAU     = 31'd335544;
  localparam logic [30:0] RST_POS_LIM = 31'd40265318;
  localparam logic [30:0] RST_ANG_LIM = 31'd3513812;

  // physics constants in Q8.24
  localparam logic signed [31:0] K_1_20  = 32'sd838861;
  localparam logic signed [31:0] K_10_11 = 32'sd15252015;
  localparam logic signed [31:0] K_9_8   = 32'sd164416717;
  localparam logic signed [31:0] K_1_11  = 32'sd1525201;
  localparam logic signed [31:0] K_4_3   = 32'sd22369621;
  localparam logic signed [31:0] K_HALF  = 32'sd8388608;
  localparam logic signed [31:0] K_1_22  = 32'sd762601;

  localparam logic signed [31:0] PI_Q      = 32'sd52707179;
  localparam logic signed [31:0] TWO_PI_Q  = 32'sd105414357;
  localparam logic signed [31:0] HALF_PI_Q = 32'sd26353589;
  localparam logic signed [31:0] CORDIC_X0 = 32'sd10188014;
  localparam int                 CORDIC_N  = 24;

  localparam logic signed [31:0] WORD_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] WORD_MIN = 32'sh80000000;

  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_ADD = 2'd1,
    OP_SUB = 2'd2,
    OP_DIV = 2'd3
  } alu_op_t;

  typedef enum logic [4:0] {
    SRC_RATE, SRC_POS, SRC_VEL, SRC_ANG, SRC_SIN, SRC_COS, SRC_T0, SRC_T1,
    SRC_NUM, SRC_DEN, SRC_THACC, SRC_XACC, SRC_FORCE, SRC_TAU, SRC_K120,
    SRC_K1011, SRC_K98, SRC_K111, SRC_K43, SRC_KHALF, SRC_K122
  } src_t;

  typedef enum logic [3:0] {
    DST_T0, DST_T1, DST_NUM, DST_DEN, DST_THACC, DST_XACC,
    DST_POS, DST_VEL, DST_ANG, DST_RATE
  } dst_t;

  typedef struct packed {
    alu_op_t op;
    src_t    a;
    src_t    b;
    dst_t    d;
  } uop_t;

  localparam logic [4:0] PROG_LAST = 5'd23;

  function automatic logic [31:0] mag32(logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  // atan(2^-i) in Q8.24
  function automatic logic signed [31:0] atan_q(logic [4:0] i);
    logic signed [31:0] a;
    case (i)
      5'd0:  a = 32'sd13176795;
      5'd1:  a = 32'sd7778716;
      5'd2:  a = 32'sd4110060;
      5'd3:  a = 32'sd2086331;
      5'd4:  a = 32'sd1047214;
      5'd5:  a = 32'sd524117;
      5'd6:  a = 32'sd262123;
      5'd7:  a = 32'sd131069;
      5'd8:  a = 32'sd65536;
      5'd9:  a = 32'sd32768;
      5'd10: a = 32'sd16384;
      5'd11: a = 32'sd8192;
      5'd12: a = 32'sd4096;
      5'd13: a = 32'sd2048;
      5'd14: a = 32'sd1024;
      5'd15: a = 32'sd512;
      5'd16: a = 32'sd256;
      5'd17: a = 32'sd128;
      5'd18: a = 32'sd64;
      5'd19: a = 32'sd32;
      5'd20: a = 32'sd16;
      5'd21: a = 32'sd8;
      5'd22: a = 32'sd4;
      5'd23: a = 32'sd2;
      default: a = 32'sd0;
    endcase
    return a;
  endfunction

  // step program after sin/cos are known
  function automatic uop_t ucode(logic [4:0] pc);
    uop_t u;
    case (pc)
      5'd0:  u = '{OP_MUL, SRC_RATE,  SRC_RATE,  DST_T1};
      5'd1:  u = '{OP_MUL, SRC_K120,  SRC_T1,    DST_T1};
      5'd2:  u = '{OP_MUL, SRC_T1,    SRC_SIN,   DST_T0};
      5'd3:  u = '{OP_ADD, SRC_FORCE, SRC_T0,    DST_T0};
      5'd4:  u = '{OP_MUL, SRC_T0,    SRC_K1011, DST_T0};
      5'd5:  u = '{OP_MUL, SRC_K98,   SRC_SIN,   DST_T1};
      5'd6:  u = '{OP_MUL, SRC_COS,   SRC_T0,    DST_NUM};
      5'd7:  u = '{OP_SUB, SRC_T1,    SRC_NUM,   DST_NUM};
      5'd8:  u = '{OP_MUL, SRC_COS,   SRC_COS,   DST_T1};
      5'd9:  u = '{OP_MUL, SRC_K111,  SRC_T1,    DST_T1};
      5'd10: u = '{OP_SUB, SRC_K43,   SRC_T1,    DST_T1};
      5'd11: u = '{OP_MUL, SRC_KHALF, SRC_T1,    DST_DEN};
      5'd12: u = '{OP_DIV, SRC_NUM,   SRC_DEN,   DST_THACC};
      5'd13: u = '{OP_MUL, SRC_K122,  SRC_THACC, DST_T1};
      5'd14: u = '{OP_MUL, SRC_T1,    SRC_COS,   DST_T1};
      5'd15: u = '{OP_SUB, SRC_T0,    SRC_T1,    DST_XACC};
      5'd16: u = '{OP_MUL, SRC_TAU,   SRC_VEL,   DST_T1};
      5'd17: u = '{OP_ADD, SRC_POS,   SRC_T1,    DST_POS};
      5'd18: u = '{OP_MUL, SRC_TAU,   SRC_XACC,  DST_T1};
      5'd19: u = '{OP_ADD, SRC_VEL,   SRC_T1,    DST_VEL};
      5'd20: u = '{OP_MUL, SRC_TAU,   SRC_RATE,  DST_T1};
      5'd21: u = '{OP_ADD, SRC_ANG,   SRC_T1,    DST_ANG};
      5'd22: u = '{OP_MUL, SRC_TAU,   SRC_THACC, DST_T1};
      default: u = '{OP_ADD, SRC_RATE, SRC_T1,   DST_RATE};
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

@@ design/cart_pole_dynamics_step_core.sv @@
`timescale 1ns / 1ps
// load request: result registered in ST_FIN once the output is free, then back to ST_IDLE
// step request: sine/cosine first, then the microcode program: the 2-bit-per-cycle divider,
//   15 multiplies, 8 saturating adds and subtracts, and the finishing state
// one request in flight: after a step the next request is accepted only back in ST_IDLE;
//   a result not yet taken holds the core until out_ready
// sync active-low reset clears the cart-pole state and loads default config
// ---------------------------------------------------------------------------
// cart_pole_dynamics_step_core
// cart-pole Euler step with a microcoded shared arithmetic unit
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cart_pole_dynamics_step_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire cpds_pkg::in_t   in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output cpds_pkg::out_t       out_data,
  input  wire logic            cfg_we,
  input  wire logic [1:0]      cfg_index,
  input  wire logic [30:0]     cfg_wdata
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_TRIG = 4'b0010,
    ST_PROG = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [4:0] pc_r, pc_nxt;
  logic       ph_r, ph_nxt;

  logic [30:0] force_r, tau_r, plim_r, alim_r;
  logic signed [31:0] pos_r, vel_r, ang_r, rate_r;
  logic signed [31:0] t0_r, t1_r, num_r, den_r, thacc_r, xacc_r;
  logic        push_r;
  logic        out_valid_r;
  cpds_pkg::out_t out_data_r;

  logic        accept;
  logic        cordic_busy, cordic_done, div_busy, div_done, div_start;
  logic signed [31:0] sin_q, cos_q, div_q, alu_y;
  logic signed [31:0] opa, opb, wr_val, force_val, tau_val;
  logic        wr_en, out_free;
  cpds_pkg::uop_t u;
  cpds_pkg::alu_op_t alu_op;
  logic signed [32:0] pos_x, ang_x, pl_x, al_x;

  assign accept    = in_valid && in_ready;
  assign in_ready  = state_r == ST_IDLE;
  assign out_free  = !out_valid_r || out_ready;
  assign u         = cpds_pkg::ucode(pc_r);
  assign force_val = push_r ? $signed({1'b0, force_r}) : -$signed({1'b0, force_r});
  assign tau_val   = $signed({1'b0, tau_r});
  assign alu_op    = (state_r == ST_PROG) ? u.op : cpds_pkg::OP_ADD;

  always_comb begin
    case (u.a)
      cpds_pkg::SRC_RATE:  opa = rate_r;
      cpds_pkg::SRC_POS:   opa = pos_r;
      cpds_pkg::SRC_VEL:   opa = vel_r;
      cpds_pkg::SRC_ANG:   opa = ang_r;
      cpds_pkg::SRC_SIN:   opa = sin_q;
      cpds_pkg::SRC_COS:   opa = cos_q;
      cpds_pkg::SRC_T0:    opa = t0_r;
      cpds_pkg::SRC_T1:    opa = t1_r;
      cpds_pkg::SRC_NUM:   opa = num_r;
      cpds_pkg::SRC_DEN:   opa = den_r;
      cpds_pkg::SRC_THACC: opa = thacc_r;
      cpds_pkg::SRC_XACC:  opa = xacc_r;
      cpds_pkg::SRC_FORCE: opa = force_val;
      cpds_pkg::SRC_TAU:   opa = tau_val;
      cpds_pkg::SRC_K120:  opa = cpds_pkg::K_1_20;
      cpds_pkg::SRC_K1011: opa = cpds_pkg::K_10_11;
      cpds_pkg::SRC_K98:   opa = cpds_pkg::K_9_8;
      cpds_pkg::SRC_K111:  opa = cpds_pkg::K_1_11;
      cpds_pkg::SRC_K43:   opa = cpds_pkg::K_4_3;
      cpds_pkg::SRC_KHALF: opa = cpds_pkg::K_HALF;
      cpds_pkg::SRC_K122:  opa = cpds_pkg::K_1_22;
      default:             opa = '0;
    endcase
  end

  always_comb begin
    case (u.b)
      cpds_pkg::SRC_RATE:  opb = rate_r;
      cpds_pkg::SRC_POS:   opb = pos_r;
      cpds_pkg::SRC_VEL:   opb = vel_r;
      cpds_pkg::SRC_ANG:   opb = ang_r;
      cpds_pkg::SRC_SIN:   opb = sin_q;
      cpds_pkg::SRC_COS:   opb = cos_q;
      cpds_pkg::SRC_T0:    opb = t0_r;
      cpds_pkg::SRC_T1:    opb = t1_r;
      cpds_pkg::SRC_NUM:   opb = num_r;
      cpds_pkg::SRC_DEN:   opb = den_r;
      cpds_pkg::SRC_THACC: opb = thacc_r;
      cpds_pkg::SRC_XACC:  opb = xacc_r;
      cpds_pkg::SRC_FORCE: opb = force_val;
      cpds_pkg::SRC_TAU:   opb = tau_val;
      cpds_pkg::SRC_K120:  opb = cpds_pkg::K_1_20;
      cpds_pkg::SRC_K1011: opb = cpds_pkg::K_10_11;
      cpds_pkg::SRC_K98:   opb = cpds_pkg::K_9_8;
      cpds_pkg::SRC_K111:  opb = cpds_pkg::K_1_11;
      cpds_pkg::SRC_K43:   opb = cpds_pkg::K_4_3;
      cpds_pkg::SRC_KHALF: opb = cpds_pkg::K_HALF;
      cpds_pkg::SRC_K122:  opb = cpds_pkg::K_1_22;
      default:             opb = '0;
    endcase
  end

  cpds_alu u_alu (
    .clk    (clk),
    .op     (alu_op),
    .opa    (opa),
    .opb    (opb),
    .result (alu_y)
  );

  cpds_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (opa),
    .divisor  (opb),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  cpds_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept && !in_data.kind),
    .theta (ang_r),
    .busy  (cordic_busy),
    .done  (cordic_done),
    .sin_q (sin_q),
    .cos_q (cos_q)
  );

  // sequencer: multiplies take two phases, divide waits for the unit
  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    ph_nxt    = ph_r;
    wr_en     = 1'b0;
    wr_val    = alu_y;
    div_start = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = in_data.kind ? ST_FIN : ST_TRIG;
      end
      ST_TRIG: begin
        pc_nxt = '0;
        ph_nxt = 1'b0;
        if (cordic_done) state_nxt = ST_PROG;
      end
      ST_PROG: begin
        case (u.op)
          cpds_pkg::OP_MUL: begin
            ph_nxt = !ph_r;
            wr_en  = ph_r;
          end
          cpds_pkg::OP_DIV: begin
            div_start = !ph_r;
            ph_nxt    = !(ph_r && div_done);
            wr_en     = ph_r && div_done;
            wr_val    = div_q;
          end
          default: wr_en = 1'b1;
        endcase
        if (wr_en) begin
          if (pc_r == cpds_pkg::PROG_LAST) state_nxt = ST_FIN;
          else pc_nxt = pc_r + 5'd1;
        end
      end
      ST_FIN: begin
        if (out_free) state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pc_r        <= '0;
      ph_r        <= 1'b0;
      out_valid_r <= 1'b0;
      force_r     <= cpds_pkg::RST_FORCE;
      tau_r       <= cpds_pkg::RST_TAU;
      plim_r      <= cpds_pkg::RST_POS_LIM;
      alim_r      <= cpds_pkg::RST_ANG_LIM;
      pos_r       <= '0;
      vel_r       <= '0;
      ang_r       <= '0;
      rate_r      <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      ph_r    <= ph_nxt;
      if (state_r == ST_FIN && out_free) out_valid_r <= 1'b1;
      else if (out_ready)                out_valid_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          cpds_pkg::REG_FORCE:   force_r <= cfg_wdata;
          cpds_pkg::REG_TAU:     tau_r   <= cfg_wdata;
          cpds_pkg::REG_POS_LIM: plim_r  <= cfg_wdata;
          cpds_pkg::REG_ANG_LIM: alim_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (accept && in_data.kind) begin
        pos_r  <= in_data.load_position;
        vel_r  <= in_data.load_velocity;
        ang_r  <= in_data.load_angle;
        rate_r <= in_data.load_angular_rate;
      end else if (wr_en) begin
        case (u.d)
          cpds_pkg::DST_POS:  pos_r  <= wr_val;
          cpds_pkg::DST_VEL:  vel_r  <= wr_val;
          cpds_pkg::DST_ANG:  ang_r  <= wr_val;
          cpds_pkg::DST_RATE: rate_r <= wr_val;
          default: ;
        endcase
      end
    end
  end

  // scratch registers and output payload
  always_ff @(posedge clk) begin
    if (accept) push_r <= in_data.push_right;
    if (wr_en) begin
      case (u.d)
        cpds_pkg::DST_T0:    t0_r    <= wr_val;
        cpds_pkg::DST_T1:    t1_r    <= wr_val;
        cpds_pkg::DST_NUM:   num_r   <= wr_val;
        cpds_pkg::DST_DEN:   den_r   <= wr_val;
        cpds_pkg::DST_THACC: thacc_r <= wr_val;
        cpds_pkg::DST_XACC:  xacc_r  <= wr_val;
        default: ;
      endcase
    end
    if (state_r == ST_FIN && out_free) begin
      out_data_r.position     <= pos_r;
      out_data_r.velocity     <= vel_r;
      out_data_r.angle        <= ang_r;
      out_data_r.angular_rate <= rate_r;
      out_data_r.terminated   <= (pos_x > pl_x) || (pos_x < -pl_x) ||
                                 (ang_x > al_x) || (ang_x < -al_x);
    end
  end

  assign pos_x = 33'(pos_r);
  assign ang_x = 33'(ang_r);
  assign pl_x  = $signed({2'b00, plim_r});
  assign al_x  = $signed({2'b00, alim_r});

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_SAME(a_idle_units_quiet, state_r == ST_IDLE, !cordic_busy && !div_busy)
  `ASSERT_NEXT(a_load_to_fin, accept && in_data.kind, state_r == ST_FIN)
  `ASSERT_SAME(a_cordic_done_in_trig, cordic_done, state_r == ST_TRIG)
  `ASSERT_SAME(a_div_done_in_prog, div_done, state_r == ST_PROG && u.op == cpds_pkg::OP_DIV)

endmodule

`default_nettype wire

@@ design/cpds_alu.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cpds_alu
// shared multiply / saturating add-subtract unit, Q8.24
// ---------------------------------------------------------------------------
`default_nettype none

module cpds_alu (
  input  wire logic                  clk,
  input  wire cpds_pkg::alu_op_t     op,
  input  wire logic signed [31:0]    opa,
  input  wire logic signed [31:0]    opb,
  output logic signed [31:0]         result
);

  logic [63:0] prod_r;
  logic        neg_r;
  logic [63:0] rnd;
  logic [39:0] shr;
  logic [39:0] lim;
  logic signed [32:0] sum;

  // multiply: registered magnitude product and sign
  always_ff @(posedge clk) begin
    if (op == cpds_pkg::OP_MUL) begin
      prod_r <= 64'(cpds_pkg::mag32(opa)) * 64'(cpds_pkg::mag32(opb));
      neg_r  <= opa[31] ^ opb[31];
    end
  end

  always_comb begin
    rnd = prod_r + (64'd1 << (cpds_pkg::FRAC_W - 1));
    shr = rnd[63:24];
    lim = neg_r ? 40'h0080000000 : 40'h007fffffff;
    sum = '0;
    unique case (op)
      cpds_pkg::OP_MUL: begin
        if (shr > lim) result = neg_r ? cpds_pkg::WORD_MIN : cpds_pkg::WORD_MAX;
        else           result = neg_r ? -$signed(shr[31:0]) : $signed(shr[31:0]);
      end
      cpds_pkg::OP_ADD, cpds_pkg::OP_SUB: begin
        sum = (op == cpds_pkg::OP_ADD) ? (33'(opa) + 33'(opb)) : (33'(opa) - 33'(opb));
        if (sum[32] != sum[31]) result = sum[32] ? cpds_pkg::WORD_MIN : cpds_pkg::WORD_MAX;
        else                    result = sum[31:0];
      end
      cpds_pkg::OP_DIV: result = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ design/cpds_div.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cpds_div
// restoring Q8.24 divider, two quotient bits per cycle, rounded and saturated
// ---------------------------------------------------------------------------
`default_nettype none

module cpds_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [31:0] dividend,
  input  wire logic signed [31:0] divisor,
  output logic                    busy,
  output logic                    done,
  output logic signed [31:0]      quotient
);

  typedef enum logic [2:0] {
    D_IDLE  = 3'b001,
    D_RUN   = 3'b010,
    D_ROUND = 3'b100
  } dstate_t;

  dstate_t     state_r, state_nxt;
  logic [4:0]  cnt_r;
  logic [55:0] nq_r;
  logic [31:0] rem_r;
  logic [31:0] d_r;
  logic        neg_r;
  logic        done_r;
  logic signed [31:0] quot_r;

  logic [32:0] r2a, r2b;
  logic        ga, gb;
  logic [31:0] rema, remb;
  logic        up;
  logic [55:0] q1;
  logic [55:0] lim;

  always_comb begin
    r2a  = {rem_r, nq_r[55]};
    ga   = r2a >= {1'b0, d_r};
    rema = ga ? 32'(r2a - {1'b0, d_r}) : r2a[31:0];
    r2b  = {rema, nq_r[54]};
    gb   = r2b >= {1'b0, d_r};
    remb = gb ? 32'(r2b - {1'b0, d_r}) : r2b[31:0];
    up   = rem_r >= (d_r - rem_r);
    q1   = nq_r + 56'(up);
    lim  = neg_r ? 56'h80000000 : 56'h7fffffff;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      D_IDLE:  if (start && divisor != '0) state_nxt = D_RUN;
      D_RUN:   if (cnt_r == 5'd27) state_nxt = D_ROUND;
      D_ROUND: state_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == D_ROUND) || (state_r == D_IDLE && start && divisor == '0);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      D_IDLE: begin
        nq_r  <= {24'd0, cpds_pkg::mag32(dividend)} << cpds_pkg::FRAC_W;
        rem_r <= '0;
        d_r   <= cpds_pkg::mag32(divisor);
        neg_r <= dividend[31] ^ divisor[31];
        cnt_r <= '0;
        // zero divisor: signed bound, zero over zero gives zero
        if (dividend == '0)     quot_r <= '0;
        else if (dividend[31])  quot_r <= cpds_pkg::WORD_MIN;
        else                    quot_r <= cpds_pkg::WORD_MAX;
      end
      D_RUN: begin
        nq_r  <= {nq_r[53:0], ga, gb};
        rem_r <= remb;
        cnt_r <= cnt_r + 5'd1;
      end
      D_ROUND: begin
        if (q1 > lim) quot_r <= neg_r ? cpds_pkg::WORD_MIN : cpds_pkg::WORD_MAX;
        else          quot_r <= neg_r ? -$signed(q1[31:0]) : $signed(q1[31:0]);
      end
    endcase
  end

  assign busy     = state_r != D_IDLE;
  assign done     = done_r;
  assign quotient = quot_r;

endmodule

`default_nettype wire

@@ design/cpds_cordic.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cpds_cordic
// angle reduction and 24-step rotation-mode sine/cosine
// ---------------------------------------------------------------------------
`default_nettype none

module cpds_cordic (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [31:0] theta,
  output logic                    busy,
  output logic                    done,
  output logic signed [31:0]      sin_q,
  output logic signed [31:0]      cos_q
);

  typedef enum logic [4:0] {
    C_IDLE = 5'b00001,
    C_MOD  = 5'b00010,
    C_WRAP = 5'b00100,
    C_FOLD = 5'b01000,
    C_ITER = 5'b10000
  } cstate_t;

  cstate_t     state_r, state_nxt;
  logic [2:0]  k_r;
  logic [4:0]  i_r;
  logic [31:0] zmag_r;
  logic        zneg_r;
  logic        flip_r;
  logic        done_r;
  logic signed [31:0] z_r, x_r, y_r, sin_r, cos_r;

  logic [31:0] sub_val;
  logic [31:0] zmag_nxt;
  logic signed [31:0] xs, ys, nx, ny, nz, ang;

  always_comb begin
    sub_val  = 32'(cpds_pkg::TWO_PI_Q) << k_r;
    zmag_nxt = (zmag_r >= sub_val) ? zmag_r - sub_val : zmag_r;
    xs  = x_r >>> i_r;
    ys  = y_r >>> i_r;
    ang = cpds_pkg::atan_q(i_r);
    if (!z_r[31]) begin
      nx = x_r - ys; ny = y_r + xs; nz = z_r - ang;
    end else begin
      nx = x_r + ys; ny = y_r - xs; nz = z_r + ang;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      C_IDLE: if (start) state_nxt = C_MOD;
      C_MOD:  if (k_r == '0) state_nxt = C_WRAP;
      C_WRAP: state_nxt = C_FOLD;
      C_FOLD: state_nxt = C_ITER;
      C_ITER: if (i_r == 5'(cpds_pkg::CORDIC_N - 1)) state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == C_ITER) && (i_r == 5'(cpds_pkg::CORDIC_N - 1));
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      C_IDLE: begin
        zmag_r <= cpds_pkg::mag32(theta);
        zneg_r <= theta[31];
        k_r    <= 3'd4;
      end
      C_MOD: begin
        zmag_r <= zmag_nxt;
        k_r    <= k_r - 3'd1;
        // remainder keeps the dividend's sign
        if (k_r == '0) z_r <= zneg_r ? -$signed(zmag_nxt) : $signed(zmag_nxt);
      end
      C_WRAP: begin
        if (z_r > cpds_pkg::PI_Q)       z_r <= z_r - cpds_pkg::TWO_PI_Q;
        else if (z_r < -cpds_pkg::PI_Q) z_r <= z_r + cpds_pkg::TWO_PI_Q;
      end
      C_FOLD: begin
        flip_r <= 1'b0;
        x_r    <= cpds_pkg::CORDIC_X0;
        y_r    <= '0;
        i_r    <= '0;
        if (z_r > cpds_pkg::HALF_PI_Q) begin
          z_r <= cpds_pkg::PI_Q - z_r; flip_r <= 1'b1;
        end else if (z_r < -cpds_pkg::HALF_PI_Q) begin
          z_r <= -cpds_pkg::PI_Q - z_r; flip_r <= 1'b1;
        end
      end
      C_ITER: begin
        x_r <= nx;
        y_r <= ny;
        z_r <= nz;
        i_r <= i_r + 5'd1;
        if (i_r == 5'(cpds_pkg::CORDIC_N - 1)) begin
          sin_r <= ny;
          cos_r <= flip_r ? -nx : nx;
        end
      end
    endcase
  end

  assign busy  = state_r != C_IDLE;
  assign done  = done_r;
  assign sin_q = sin_r;
  assign cos_q = cos_r;

endmodule

`default_nettype wire

@@ tb/cpds_step_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cpds_step_checker
// watches the request, result and config ports of the cart-pole step core, predicts each
// result in fixed point, compares the whole result and shows each field on the first ten mismatches
// ---------------------------------------------------------------------------

module cpds_step_checker
  import cpds_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_t         in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_t        out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_wdata,
  output int          fail_count,
  output int          pending
);

  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;

  localparam longint C_1_20  = 838861;
  localparam longint C_10_11 = 15252015;
  localparam longint C_9_8   = 164416717;
  localparam longint C_1_11  = 1525201;
  localparam longint C_4_3   = 22369621;
  localparam longint C_HALF  = 8388608;
  localparam longint C_1_22  = 762601;

  longint force_mag, tau, pos_lim, ang_lim;
  longint cart_pos, cart_vel, pole_ang, pole_rate;
  longint atan_lut [24];
  out_t   expected_states [$];
  int     mismatches;

  initial begin
    for (int i = 0; i < 24; i++) begin
      atan_lut[i] = longint'($atan(2.0 ** (-i)) * 16777216.0);
    end
    mismatches = 0;
  end

  assign fail_count = mismatches;
  assign pending    = expected_states.size();

  function automatic longint sat_q(longint v);
    return v > Q_MAX ? Q_MAX : (v < Q_MIN ? Q_MIN : v);
  endfunction

  function automatic logic [63:0] abs_q(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint sat_signed(logic neg, logic [127:0] m);
    logic [127:0] lim;
    lim = neg ? 128'd2147483648 : 128'd2147483647;
    if (m > lim) return neg ? Q_MIN : Q_MAX;
    return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    logic [127:0] m;
    m = 128'(abs_q(a)) * 128'(abs_q(b));
    m = (m + (128'd1 << 23)) >> 24;
    return sat_signed((a < 0) != (b < 0), m);
  endfunction

  function automatic longint fx_div(longint a, longint b);
    logic [127:0] n, d, q, r;
    if (b == 0) return a == 0 ? 0 : (a > 0 ? Q_MAX : Q_MIN);
    n = 128'(abs_q(a)) << 24;
    d = 128'(abs_q(b));
    q = n / d;
    r = n % d;
    if (r >= d - r) q = q + 1;
    return sat_signed((a < 0) != (b < 0), q);
  endfunction

  task automatic pole_sin_cos(input longint th, output longint s, output longint c);
    longint x, y, z, nx;
    logic   flip;
    x = CORDIC_X0;
    y = 0;
    flip = 1'b0;
    z = th % longint'(TWO_PI_Q);
    if (z > PI_Q) z = z - TWO_PI_Q;
    if (z < -longint'(PI_Q)) z = z + TWO_PI_Q;
    // fold into the right half plane, cosine changes sign
    if (z > HALF_PI_Q) begin
      z = PI_Q - z;
      flip = 1'b1;
    end else if (z < -longint'(HALF_PI_Q)) begin
      z = -longint'(PI_Q) - z;
      flip = 1'b1;
    end
    for (int i = 0; i < 24; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - atan_lut[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + atan_lut[i];
      end
      x = nx;
    end
    s = sat_q(y);
    c = sat_q(flip ? -x : x);
  endtask

  task automatic advance_state(input in_t req, output out_t res);
    longint frc, s, c, temp, num, den, thacc, xacc;
    if (req.kind) begin
      cart_pos  = longint'(req.load_position);
      cart_vel  = longint'(req.load_velocity);
      pole_ang  = longint'(req.load_angle);
      pole_rate = longint'(req.load_angular_rate);
    end else begin
      frc = req.push_right ? force_mag : -force_mag;
      pole_sin_cos(pole_ang, s, c);
      temp  = fx_mul(fx_mul(C_1_20, fx_mul(pole_rate, pole_rate)), s);
      temp  = fx_mul(sat_q(frc + temp), C_10_11);
      num   = sat_q(fx_mul(C_9_8, s) - fx_mul(c, temp));
      den   = fx_mul(C_HALF, sat_q(C_4_3 - fx_mul(C_1_11, fx_mul(c, c))));
      thacc = fx_div(num, den);
      xacc  = sat_q(temp - fx_mul(fx_mul(C_1_22, thacc), c));
      cart_pos  = sat_q(cart_pos + fx_mul(tau, cart_vel));
      cart_vel  = sat_q(cart_vel + fx_mul(tau, xacc));
      pole_ang  = sat_q(pole_ang + fx_mul(tau, pole_rate));
      pole_rate = sat_q(pole_rate + fx_mul(tau, thacc));
    end
    res.position     = 32'(cart_pos);
    res.velocity     = 32'(cart_vel);
    res.angle        = 32'(pole_ang);
    res.angular_rate = 32'(pole_rate);
    res.terminated   = (cart_pos < -pos_lim || cart_pos > pos_lim ||
                        pole_ang < -ang_lim || pole_ang > ang_lim);
  endtask

  always @(posedge clk) begin
    out_t res, exp_res;
    if (!rst_n) begin
      force_mag = RST_FORCE;
      tau       = RST_TAU;
      pos_lim   = RST_POS_LIM;
      ang_lim   = RST_ANG_LIM;
      cart_pos  = 0;
      cart_vel  = 0;
      pole_ang  = 0;
      pole_rate = 0;
      expected_states.delete();
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_FORCE:   force_mag = cfg_wdata;
          REG_TAU:     tau       = cfg_wdata;
          REG_POS_LIM: pos_lim   = cfg_wdata;
          REG_ANG_LIM: ang_lim   = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_states.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", out_data);
        end else begin
          exp_res = expected_states.pop_front();
          if (out_data !== exp_res) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch pos %h/%h vel %h/%h ang %h/%h rate %h/%h term %b/%b",
                       exp_res.position, out_data.position,
                       exp_res.velocity, out_data.velocity,
                       exp_res.angle, out_data.angle,
                       exp_res.angular_rate, out_data.angular_rate,
                       exp_res.terminated, out_data.terminated);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        advance_state(in_data, res);
        expected_states.push_back(res);
      end
    end
  end

endmodule

@@ tb/tb_cart_pole_dynamics_step_core.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_cart_pole_dynamics_step_core
// drives load and step requests under several config settings with random
// idling on both channels; a checker beside the core predicts the results
// ---------------------------------------------------------------------------

module tb_cart_pole_dynamics_step_core;
  import cpds_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [30:0] cfg_wdata = '0;
  int          fail_count, pending;
  int          cycles = 0;
  int          sent = 0;
  logic        burst = 1'b0;

  always #1 clk = ~clk;

  cart_pole_dynamics_step_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  cpds_step_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side stalls
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      gap = burst ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send_req(input in_t req);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 14);
    repeat (gap) @(negedge clk);
    in_data  = req;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
    sent++;
  endtask

  function automatic in_t load_req(int p, int v, int a, int r);
    in_t q;
    q = '{kind: 1'b1, push_right: 1'($urandom), load_position: p,
          load_velocity: v, load_angle: a, load_angular_rate: r};
    return q;
  endfunction

  function automatic in_t step_req(logic push);
    in_t q;
    q = '{kind: 1'b0, push_right: push, load_position: $urandom,
          load_velocity: $urandom, load_angle: $urandom, load_angular_rate: $urandom};
    return q;
  endfunction

  function automatic int near(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic wait_idle();
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [30:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    int target, n;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes, both pushes, large angle folding, saturation
    send_req(step_req(1'b1));
    send_req(step_req(1'b0));
    send_req(load_req(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
    send_req(step_req(1'b1));
    send_req(load_req(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000));
    send_req(step_req(1'b0));
    send_req(load_req(0, 0, 0, 0));
    send_req(step_req(1'b1));
    send_req(load_req(0, 0, PI_Q, 0));
    send_req(step_req(1'b0));
    send_req(load_req(0, 0, -PI_Q, 0));
    send_req(step_req(1'b1));
    send_req(load_req(0, 0, HALF_PI_Q + 1, 0));
    send_req(step_req(1'b1));
    send_req(load_req(0, 0, -HALF_PI_Q - 1, 0));
    send_req(step_req(1'b0));
    send_req(load_req(0, 0, 32'sd1677721600, 32'sd167772160));
    send_req(step_req(1'b1));
    send_req(load_req(32'sd40265318, 0, 32'sd3513812, 0));
    send_req(load_req(32'sd40265319, 0, -32'sd3513813, 0));
    send_req(load_req(-32'sd40265318, 0, -32'sd3513812, 0));
    send_req(step_req(1'b0));

    for (int phase = 0; phase < 10; phase++) begin
      // sender holds off until the core has drained
      wait_idle();
      case (phase)
        0: begin
          write_reg(REG_FORCE, '0);
          write_reg(REG_TAU, '0);
          write_reg(REG_POS_LIM, '0);
          write_reg(REG_ANG_LIM, '0);
        end
        1: begin
          write_reg(REG_FORCE, '1);
          write_reg(REG_TAU, '1);
          write_reg(REG_POS_LIM, '1);
          write_reg(REG_ANG_LIM, '1);
        end
        2: begin
          write_reg(REG_FORCE, RST_FORCE);
          write_reg(REG_TAU, RST_TAU);
          write_reg(REG_POS_LIM, RST_POS_LIM);
          write_reg(REG_ANG_LIM, RST_ANG_LIM);
        end
        default: begin
          write_reg(REG_FORCE, $urandom_range(0, 3) == 0 ? 31'($urandom)
                                                         : 31'($urandom_range(0, 1 << 29)));
          write_reg(REG_TAU, $urandom_range(0, 3) == 0 ? 31'($urandom)
                                                       : 31'($urandom_range(0, 1 << 22)));
          write_reg(REG_POS_LIM, 31'($urandom_range(0, 1 << 27)));
          write_reg(REG_ANG_LIM, $urandom_range(0, 3) == 0 ? 31'($urandom)
                                                           : 31'($urandom_range(0, 1 << 23)));
        end
      endcase
      burst  = (phase % 3 == 2);
      target = sent + 105;
      while (sent < target) begin
        case ($urandom_range(0, 19))
          0, 1, 2: begin
            send_req(load_req($urandom, $urandom, $urandom, $urandom));
            n = $urandom_range(0, 4);
          end
          3, 4, 5: n = $urandom_range(1, 6);
          default: begin
            send_req(load_req(near(1 << 26), near(1 << 25), near(1 << 23), near(1 << 25)));
            n = $urandom_range(5, 20);
          end
        endcase
        repeat (n) send_req(step_req(1'($urandom)));
      end
    end

    burst = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (150) @(negedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
